// ===== rtl/sha1sh_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// SHA-1 stream hash package
// Shared payload types, command and status structs and hash constants.
// ----------------------------------------------------------------------------
package sha1sh_pkg;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       byte_valid;
    logic       last;
  } in_item_t;

  typedef struct packed {
    logic [31:0] digest_word;
    logic [2:0]  word_index;
    logic        last_word;
  } out_item_t;

  typedef enum logic [1:0] {
    SEL_DATA = 2'd0,
    SEL_PAD  = 2'd1,
    SEL_ZERO = 2'd2,
    SEL_LEN  = 2'd3
  } byte_sel_t;

  typedef enum logic [1:0] {
    PH_CH  = 2'd0,
    PH_P1  = 2'd1,
    PH_MAJ = 2'd2,
    PH_P2  = 2'd3
  } round_phase_t;

  typedef struct packed {
    logic         put_en;
    byte_sel_t    put_sel;
    logic         count_en;
    logic         round_en;
    round_phase_t phase;
    logic         fin_en;
    logic         reinit;
    logic [2:0]   out_index;
  } core_cmd_t;

  typedef struct packed {
    logic pos_63;
    logic pos_55;
  } core_stat_t;

  localparam logic [31:0] H0_INIT = 32'h67452301;
  localparam logic [31:0] H1_INIT = 32'hEFCDAB89;
  localparam logic [31:0] H2_INIT = 32'h98BADCFE;
  localparam logic [31:0] H3_INIT = 32'h10325476;
  localparam logic [31:0] H4_INIT = 32'hC3D2E1F0;

  localparam logic [31:0] K_CH  = 32'h5A827999;
  localparam logic [31:0] K_P1  = 32'h6ED9EBA1;
  localparam logic [31:0] K_MAJ = 32'h8F1BBCDC;
  localparam logic [31:0] K_P2  = 32'hCA62C1D6;

  localparam logic [7:0] PAD_BYTE    = 8'h80;
  localparam int         ROUND_COUNT = 80;
  localparam int         DIGEST_WORDS = 5;

endpackage

// ===== rtl/sha1sh_core.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// SHA-1 stream hash datapath
// Message schedule window, round registers, chaining words and bit counter.
// ----------------------------------------------------------------------------
module sha1sh_core (
  input  logic                   clk,
  input  logic                   rst,
  input  sha1sh_pkg::core_cmd_t  cmd,
  input  logic [7:0]             data_byte,
  output sha1sh_pkg::core_stat_t stat,
  output logic [31:0]            digest_word
);
  import sha1sh_pkg::*;

  logic [31:0] w [16];
  logic [31:0] hash [5];
  logic [31:0] va, vb, vc, vd, ve;
  logic [63:0] bit_count;
  logic [5:0]  pos;

  logic [7:0]  put_byte;
  logic [31:0] f_val, k_val, t_val, w_new;

  always_comb begin
    unique case (cmd.put_sel)
      SEL_DATA: put_byte = data_byte;
      SEL_PAD:  put_byte = PAD_BYTE;
      SEL_ZERO: put_byte = 8'h00;
      SEL_LEN:  put_byte = 8'(bit_count >> {~pos[2:0], 3'b000});
      default:  put_byte = 8'h00;
    endcase
  end

  always_comb begin
    unique case (cmd.phase)
      PH_CH: begin
        f_val = (vb & vc) | (~vb & vd);
        k_val = K_CH;
      end
      PH_P1: begin
        f_val = vb ^ vc ^ vd;
        k_val = K_P1;
      end
      PH_MAJ: begin
        f_val = (vb & vc) | (vb & vd) | (vc & vd);
        k_val = K_MAJ;
      end
      PH_P2: begin
        f_val = vb ^ vc ^ vd;
        k_val = K_P2;
      end
      default: begin
        f_val = 32'h0;
        k_val = 32'h0;
      end
    endcase
  end

  assign t_val = {va[26:0], va[31:27]} + f_val + ve + k_val + w[0];

  always_comb begin
    logic [31:0] x;
    x     = w[13] ^ w[8] ^ w[2] ^ w[0];
    w_new = {x[30:0], x[31]};
  end

  assign stat.pos_63 = (pos == 6'd63);
  assign stat.pos_55 = (pos == 6'd55);
  assign digest_word = hash[cmd.out_index];

  always_ff @(posedge clk) begin
    if (cmd.put_en) begin
      w[pos[5:2]][{~pos[1:0], 3'b000} +: 8] <= put_byte;
    end else if (cmd.round_en) begin
      for (int i = 0; i < 15; i++) begin
        w[i] <= w[i + 1];
      end
      w[15] <= w_new;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.put_en && stat.pos_63) begin
      va <= hash[0];
      vb <= hash[1];
      vc <= hash[2];
      vd <= hash[3];
      ve <= hash[4];
    end else if (cmd.round_en) begin
      va <= t_val;
      vb <= va;
      vc <= {vb[1:0], vb[31:2]};
      vd <= vc;
      ve <= vd;
    end
  end

  always_ff @(posedge clk) begin
    if (rst || cmd.reinit) begin
      hash[0]   <= H0_INIT;
      hash[1]   <= H1_INIT;
      hash[2]   <= H2_INIT;
      hash[3]   <= H3_INIT;
      hash[4]   <= H4_INIT;
      bit_count <= 64'd0;
    end else begin
      if (cmd.fin_en) begin
        hash[0] <= hash[0] + va;
        hash[1] <= hash[1] + vb;
        hash[2] <= hash[2] + vc;
        hash[3] <= hash[3] + vd;
        hash[4] <= hash[4] + ve;
      end
      if (cmd.count_en) begin
        bit_count <= bit_count + 64'd8;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pos <= 6'd0;
    end else if (cmd.put_en) begin
      pos <= pos + 6'd1;
    end
  end

endmodule

// ===== rtl/sha1sh_ctrl.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// SHA-1 stream hash controller
// Sequences byte intake, padding, compression rounds and digest output.
// ----------------------------------------------------------------------------
module sha1sh_ctrl (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   in_valid,
  input  sha1sh_pkg::in_item_t   in_data,
  output logic                   in_stall,
  output logic                   out_valid,
  input  logic                   out_stall,
  input  sha1sh_pkg::core_stat_t stat,
  output sha1sh_pkg::core_cmd_t  cmd
);
  import sha1sh_pkg::*;

  typedef enum logic [6:0] {
    S_IDLE   = 7'b0000001,
    S_PAD80  = 7'b0000010,
    S_PADZ   = 7'b0000100,
    S_PADLEN = 7'b0001000,
    S_ROUND  = 7'b0010000,
    S_FIN    = 7'b0100000,
    S_OUT    = 7'b1000000
  } state_t;

  localparam logic [6:0] LAST_ROUND = 7'(ROUND_COUNT - 1);
  localparam logic [2:0] LAST_WORD  = 3'(DIGEST_WORDS - 1);

  state_t     state, state_next;
  state_t     ret_state, ret_state_next;
  logic [6:0] rnd, rnd_next;
  logic [2:0] widx, widx_next;
  logic       in_xfer, out_xfer;

  assign in_stall  = (state != S_IDLE);
  assign out_valid = (state == S_OUT);
  assign in_xfer   = in_valid && !in_stall;
  assign out_xfer  = out_valid && !out_stall;

  always_comb begin
    state_next     = state;
    ret_state_next = ret_state;
    rnd_next       = rnd;
    widx_next      = widx;
    cmd            = '0;
    cmd.put_sel    = SEL_DATA;
    cmd.out_index  = widx;
    if (rnd < 7'd20) begin
      cmd.phase = PH_CH;
    end else if (rnd < 7'd40) begin
      cmd.phase = PH_P1;
    end else if (rnd < 7'd60) begin
      cmd.phase = PH_MAJ;
    end else begin
      cmd.phase = PH_P2;
    end
    unique case (state)
      S_IDLE: begin
        if (in_xfer) begin
          if (in_data.byte_valid) begin
            cmd.put_en   = 1'b1;
            cmd.count_en = 1'b1;
          end
          if (in_data.byte_valid && stat.pos_63) begin
            state_next     = S_ROUND;
            rnd_next       = 7'd0;
            ret_state_next = in_data.last ? S_PAD80 : S_IDLE;
          end else if (in_data.last) begin
            state_next = S_PAD80;
          end
        end
      end
      S_PAD80, S_PADZ: begin
        cmd.put_en  = 1'b1;
        cmd.put_sel = (state == S_PAD80) ? SEL_PAD : SEL_ZERO;
        if (stat.pos_63) begin
          state_next     = S_ROUND;
          rnd_next       = 7'd0;
          ret_state_next = S_PADZ;
        end else if (stat.pos_55) begin
          state_next = S_PADLEN;
        end else begin
          state_next = S_PADZ;
        end
      end
      S_PADLEN: begin
        cmd.put_en  = 1'b1;
        cmd.put_sel = SEL_LEN;
        if (stat.pos_63) begin
          state_next     = S_ROUND;
          rnd_next       = 7'd0;
          ret_state_next = S_OUT;
        end
      end
      S_ROUND: begin
        cmd.round_en = 1'b1;
        rnd_next     = rnd + 7'd1;
        if (rnd == LAST_ROUND) begin
          state_next = S_FIN;
        end
      end
      S_FIN: begin
        cmd.fin_en = 1'b1;
        state_next = ret_state;
        widx_next  = 3'd0;
      end
      S_OUT: begin
        if (out_xfer) begin
          widx_next = widx + 3'd1;
          if (widx == LAST_WORD) begin
            cmd.reinit = 1'b1;
            state_next = S_IDLE;
          end
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      ret_state <= S_IDLE;
      rnd       <= 7'd0;
      widx      <= 3'd0;
    end else begin
      state     <= state_next;
      ret_state <= ret_state_next;
      rnd       <= rnd_next;
      widx      <= widx_next;
    end
  end

endmodule

// ===== rtl/sha1_stream_hash.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// SHA-1 stream hash
// Hashes a byte stream and returns the 160-bit digest as five words.
// ----------------------------------------------------------------------------
// Each input transfer carries at most one message byte and a flag that ends
// the message. Every 64th byte starts a compression that runs 80 rounds, one
// round per cycle, and then folds the result into the chaining words. The
// input is stalled while padding, rounds, the fold or the digest output run.
// Ending a message pads one byte per cycle (up to 72 bytes and one or two
// compressions) and then presents the digest as five output transfers, H0
// first, after which the block is ready for the next message.
module sha1_stream_hash (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  in_valid,
  input  sha1sh_pkg::in_item_t  in_data,
  output logic                  in_stall,
  output logic                  out_valid,
  output sha1sh_pkg::out_item_t out_data,
  input  logic                  out_stall
);
  import sha1sh_pkg::*;

  core_cmd_t   cmd;
  core_stat_t  stat;
  logic [31:0] digest_word;

  sha1sh_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_data  (in_data),
    .in_stall (in_stall),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .stat     (stat),
    .cmd      (cmd)
  );

  sha1sh_core u_core (
    .clk        (clk),
    .rst        (rst),
    .cmd        (cmd),
    .data_byte  (in_data.data_byte),
    .stat       (stat),
    .digest_word(digest_word)
  );

  assign out_data.digest_word = digest_word;
  assign out_data.word_index  = cmd.out_index;
  assign out_data.last_word   = (cmd.out_index == 3'(DIGEST_WORDS - 1));

endmodule

// ===== verif/tb_top.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// SHA-1 stream hash testbench
// Streams byte messages into the hash block and checks every digest word
// against a SHA-1 predictor kept in the bench or a digest listed in the table. A
// short table covers the empty message, a standard test vector and the field
// extremes. Random messages then cover a padding spill into a second block
// and random content with noise transfers and idle bursts on both channels.
// ----------------------------------------------------------------------------
module tb_top;
  import sha1sh_pkg::*;

  typedef logic [4:0][31:0] digest_t;

  typedef struct packed {
    in_item_t item;
    logic     typed;
    digest_t  golden;
  } stim_row_t;

  localparam int DIR_ROWS   = 17;
  localparam int IDLE_LIMIT = 4000;
  localparam int TAIL_WAIT  = 300;

  // Words are listed H4 down to H0.
  localparam digest_t EMPTY_DIGEST = {32'hafd80709, 32'h95601890, 32'h3255bfef,
                                      32'h5e6b4b0d, 32'hda39a3ee};
  localparam digest_t ABC_DIGEST   = {32'h9cd0d89d, 32'h7850c26c, 32'hba3e2571,
                                      32'h4706816a, 32'ha9993e36};

  logic      clk;
  logic      rst;
  logic      in_valid;
  in_item_t  in_data;
  logic      in_stall;
  logic      out_valid;
  out_item_t out_data;
  logic      out_stall;

  sha1_stream_hash dut (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_data   (in_data),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_data  (out_data),
    .out_stall (out_stall)
  );

  logic [31:0] chain [5];
  logic [7:0]  blk [64];
  logic [63:0] msg_bits;
  logic [5:0]  fill;

  out_item_t   digest_q [$];
  stim_row_t   dir_rows [DIR_ROWS];
  int          err_count;
  int          words_checked;
  int          msgs_done;
  int          bytes_sent;
  int          idle_cycles;
  int          stall_left;
  bit          calm;

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  function automatic logic [31:0] rol(logic [31:0] x, int n);
    return (x << n) | (x >> (32 - n));
  endfunction

  function automatic void chain_init();
    chain[0] = H0_INIT;
    chain[1] = H1_INIT;
    chain[2] = H2_INIT;
    chain[3] = H3_INIT;
    chain[4] = H4_INIT;
    msg_bits = '0;
    fill     = '0;
  endfunction

  function automatic void compress_block();
    logic [31:0] w [80];
    logic [31:0] a, b, c, d, e, f, k, t;
    for (int r = 0; r < 16; r++) begin
      w[r] = {blk[4*r], blk[4*r+1], blk[4*r+2], blk[4*r+3]};
    end
    for (int r = 16; r < 80; r++) begin
      w[r] = rol(w[r-3] ^ w[r-8] ^ w[r-14] ^ w[r-16], 1);
    end
    a = chain[0]; b = chain[1]; c = chain[2]; d = chain[3]; e = chain[4];
    for (int r = 0; r < 80; r++) begin
      if (r < 20) begin
        f = (b & c) | (~b & d);
        k = K_CH;
      end else if (r < 40) begin
        f = b ^ c ^ d;
        k = K_P1;
      end else if (r < 60) begin
        f = (b & c) | (b & d) | (c & d);
        k = K_MAJ;
      end else begin
        f = b ^ c ^ d;
        k = K_P2;
      end
      t = rol(a, 5) + f + e + k + w[r];
      e = d; d = c; c = rol(b, 30); b = a; a = t;
    end
    chain[0] += a; chain[1] += b; chain[2] += c; chain[3] += d; chain[4] += e;
  endfunction

  function automatic void absorb(logic [7:0] v);
    blk[fill] = v;
    fill = fill + 6'd1;
    if (fill == 6'd0) begin
      compress_block();
    end
  endfunction

  function automatic void hash_step(input in_item_t it, output logic done,
                                    output digest_t dig);
    logic [63:0] len;
    done = 1'b0;
    dig  = '0;
    if (it.byte_valid) begin
      msg_bits += 64'd8;
      absorb(it.data_byte);
    end
    if (it.last) begin
      len = msg_bits;
      absorb(PAD_BYTE);
      while (fill != 6'd56) absorb(8'h00);
      for (int i = 7; i >= 0; i--) absorb(len[8*i +: 8]);
      for (int i = 0; i < DIGEST_WORDS; i++) dig[i] = chain[i];
      done = 1'b1;
      chain_init();
    end
  endfunction

  function automatic stim_row_t row(logic [7:0] data, logic bv, logic fin,
                                    logic typed, digest_t golden);
    stim_row_t r;
    r.item.data_byte  = data;
    r.item.byte_valid = bv;
    r.item.last       = fin;
    r.typed           = typed;
    r.golden          = golden;
    return r;
  endfunction

  task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
    $display("[%0t] MISMATCH %s: got %h, expected %h", $realtime, what, got, want);
    err_count++;
  endtask

  task automatic send_item(input in_item_t it, input logic typed, input digest_t golden);
    logic      done;
    digest_t   dig;
    out_item_t o;
    if (!calm && $urandom_range(0, 5) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 7)) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= it;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    if (it.byte_valid) bytes_sent++;
    hash_step(it, done, dig);
    if (done) begin
      msgs_done++;
      for (int i = 0; i < DIGEST_WORDS; i++) begin
        o.digest_word = typed ? golden[i] : dig[i];
        o.word_index  = 3'(i);
        o.last_word   = (i == DIGEST_WORDS - 1);
        digest_q.push_back(o);
      end
    end
  endtask

  task automatic drain_digests();
    in_valid <= 1'b0;
    @(posedge clk);
    while (digest_q.size() != 0) @(posedge clk);
  endtask

  // Sends one message of len bytes; returns the number of counted transfers.
  task automatic send_message(input int len, input bit byte_on_last, output int sent);
    in_item_t it;
    sent = 0;
    if (len == 0) byte_on_last = 1'b0;
    for (int i = 0; i < len; i++) begin
      if ($urandom_range(0, 7) == 0) begin
        it.data_byte  = 8'($urandom);
        it.byte_valid = 1'b0;
        it.last       = 1'b0;
        send_item(it, 1'b0, '0);
      end
      it.data_byte  = 8'($urandom);
      it.byte_valid = 1'b1;
      it.last       = byte_on_last && (i == len - 1);
      send_item(it, 1'b0, '0);
      sent++;
    end
    if (!byte_on_last) begin
      it.data_byte  = 8'($urandom);
      it.byte_valid = 1'b0;
      it.last       = 1'b1;
      send_item(it, 1'b0, '0);
      sent++;
    end
  endtask

  always @(posedge clk) begin
    if (!rst && out_valid && !out_stall) begin
      if (digest_q.size() == 0) begin
        report_mismatch("digest word with none pending", out_data.digest_word, '0);
      end else begin
        if (out_data.digest_word !== digest_q[0].digest_word) begin
          report_mismatch("digest_word", out_data.digest_word, digest_q[0].digest_word);
        end
        if (out_data.word_index !== digest_q[0].word_index) begin
          report_mismatch("word_index", 32'(out_data.word_index),
                          32'(digest_q[0].word_index));
        end
        if (out_data.last_word !== digest_q[0].last_word) begin
          report_mismatch("last_word", 32'(out_data.last_word),
                          32'(digest_q[0].last_word));
        end
        void'(digest_q.pop_front());
        words_checked++;
      end
    end
    if (rst || calm) begin
      out_stall  <= 1'b0;
      stall_left <= 0;
    end else if (stall_left > 0) begin
      out_stall  <= 1'b1;
      stall_left <= stall_left - 1;
    end else if ($urandom_range(0, 5) == 0) begin
      out_stall  <= 1'b1;
      stall_left <= $urandom_range(0, 6);
    end else begin
      out_stall <= 1'b0;
    end
  end

  always @(posedge clk) begin
    if (rst || (in_valid && !in_stall) || (out_valid && !out_stall)) begin
      idle_cycles = 0;
    end else begin
      idle_cycles++;
      if (idle_cycles >= IDLE_LIMIT) begin
        $display("Timeout: no transfer for %0d cycles", IDLE_LIMIT);
        $display("Some tests failed");
        $finish;
      end
    end
  end

  initial begin
    int rand_items;
    int rand_msgs;
    int sent;
    int len;
    rst           = 1'b1;
    in_valid      = 1'b0;
    in_data       = '0;
    out_stall     = 1'b0;
    stall_left    = 0;
    calm          = 1'b0;
    err_count     = 0;
    words_checked = 0;
    msgs_done     = 0;
    bytes_sent    = 0;
    idle_cycles   = 0;
    rand_items    = 0;
    rand_msgs     = 0;
    chain_init();
    for (int i = 0; i < 64; i++) blk[i] = '0;

    dir_rows[0]  = row(8'hA5, 1'b0, 1'b1, 1'b1, EMPTY_DIGEST);
    dir_rows[1]  = row(8'h5A, 1'b0, 1'b0, 1'b0, '0);
    dir_rows[2]  = row(8'h61, 1'b1, 1'b0, 1'b0, '0);
    dir_rows[3]  = row(8'hFF, 1'b0, 1'b0, 1'b0, '0);
    dir_rows[4]  = row(8'h62, 1'b1, 1'b0, 1'b0, '0);
    dir_rows[5]  = row(8'h63, 1'b1, 1'b1, 1'b1, ABC_DIGEST);
    dir_rows[6]  = row(8'h61, 1'b1, 1'b0, 1'b0, '0);
    dir_rows[7]  = row(8'h62, 1'b1, 1'b0, 1'b0, '0);
    dir_rows[8]  = row(8'h63, 1'b1, 1'b0, 1'b0, '0);
    dir_rows[9]  = row(8'hFF, 1'b0, 1'b1, 1'b1, ABC_DIGEST);
    dir_rows[10] = row(8'h00, 1'b1, 1'b1, 1'b0, '0);
    dir_rows[11] = row(8'hFF, 1'b1, 1'b1, 1'b0, '0);
    dir_rows[12] = row(8'hFF, 1'b1, 1'b0, 1'b0, '0);
    dir_rows[13] = row(8'h00, 1'b1, 1'b0, 1'b0, '0);
    dir_rows[14] = row(8'h80, 1'b1, 1'b0, 1'b0, '0);
    dir_rows[15] = row(8'h00, 1'b0, 1'b1, 1'b0, '0);
    dir_rows[16] = row(8'h00, 1'b0, 1'b1, 1'b1, EMPTY_DIGEST);

    repeat (11) @(posedge clk);
    rst <= 1'b0;

    for (int i = 0; i < DIR_ROWS; i++) begin
      send_item(dir_rows[i].item, dir_rows[i].typed, dir_rows[i].golden);
    end
    drain_digests();

    // The first random message is 60 bytes long, so its padding no longer
    // fits the length field and spills into a second block.
    while (rand_items < 100) begin
      calm = (rand_items >= 75);
      case (rand_msgs)
        0: len = 60;
        default: len = $urandom_range(0, 12);
      endcase
      send_message(len, 1'($urandom), sent);
      rand_items += sent;
      rand_msgs++;
      if (!calm && $urandom_range(0, 4) == 0) begin
        drain_digests();
      end
    end

    drain_digests();
    repeat (TAIL_WAIT) @(posedge clk);

    $display("Covered %0d messages with %0d bytes, %0d digest words checked.",
             msgs_done, bytes_sent, words_checked);
    $display("Included empty messages, known vectors and padding into a second block.");
    if (err_count == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule

// ===== sim.f =====
rtl/sha1sh_pkg.sv
rtl/sha1sh_core.sv
rtl/sha1sh_ctrl.sv
rtl/sha1_stream_hash.sv
verif/tb_top.sv
